// File: rtl/core/gspt_pkg.sv
package gspt_pkg;

  // Field widths
  localparam int COORD_W = 11;
  localparam int SMOOTH_W = 12;
  localparam int GAIN_W = 16;
  localparam int CNT_W = 4;
  localparam int ERR_W = 13;
  localparam int DIFF_W = ERR_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int Q_SH = 8;
  localparam int Q_W = PROD_W - Q_SH;
  localparam int INTEG_W = 8;
  localparam int IACC_W = Q_W + 1;
  localparam int STEP_W = 12;
  localparam int SSUM_W = Q_W + 2;
  localparam int STEP_OUT_W = 7;
  localparam int POS_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W = 11;

  // Tuning constants
  localparam int SMOOTH_Q8 = 128;
  localparam int GATE_BASE = 100;
  localparam int GATE_STEP = 10;
  localparam int CNT_MAX = 10;
  localparam int DEAD_BAND = 5;
  localparam int INTEG_CLAMP = 100;
  localparam int STEP_CLAMP = 50;
  localparam int FRAME_HEIGHT = 1080;

  // Register reset values
  localparam logic [COORD_W-1:0] AIM_X_RST = COORD_W'(801);
  localparam logic [COORD_W-1:0] AIM_Y_RST = COORD_W'(740);
  localparam logic [GAIN_W-1:0] KP_X_RST = GAIN_W'(46);
  localparam logic [GAIN_W-1:0] KP_Y_RST = GAIN_W'(26);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AIM_X   = 3'd0,
    REG_AIM_Y   = 3'd1,
    REG_KP_X    = 3'd2,
    REG_KI_X    = 3'd3,
    REG_KD_X    = 3'd4,
    REG_KP_Y    = 3'd5,
    REG_KI_Y    = 3'd6,
    REG_KD_Y    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic                     start;
    logic signed [ERR_W-1:0]  err;
  } lane_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [STEP_W-1:0] step;
  } lane_res_t;

  typedef struct packed {
    logic                       go;
    logic signed [SMOOTH_W-1:0] raw_x;
    logic signed [SMOOTH_W-1:0] raw_y;
  } filt_req_t;

  typedef struct packed {
    logic                       accepted;
    logic signed [SMOOTH_W-1:0] smooth_x;
    logic signed [SMOOTH_W-1:0] smooth_y;
  } filt_res_t;

  // Q8.8 product scaled back, truncated toward zero
  function automatic logic signed [Q_W-1:0] qdiv(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + ((v < 0) ? PROD_W'((1 << Q_SH) - 1) : PROD_W'(0));
    return Q_W'(t >>> Q_SH);
  endfunction

  function automatic logic signed [INTEG_W-1:0] sat_integ(
      input logic signed [IACC_W-1:0] v);
    logic signed [IACC_W-1:0] lim;
    lim = IACC_W'(INTEG_CLAMP);
    if (v > lim) return INTEG_W'(INTEG_CLAMP);
    else if (v < -lim) return INTEG_W'(-INTEG_CLAMP);
    else return INTEG_W'(v);
  endfunction

  function automatic logic signed [STEP_W-1:0] sat_step(
      input logic signed [SSUM_W-1:0] v);
    logic signed [SSUM_W-1:0] lim;
    lim = SSUM_W'(STEP_CLAMP);
    if (v > lim) return STEP_W'(STEP_CLAMP);
    else if (v < -lim) return STEP_W'(-STEP_CLAMP);
    else return STEP_W'(v);
  endfunction

endpackage

// File: rtl/core/gspt_filter.sv
module gspt_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gspt_pkg::filt_req_t  req,
  output gspt_pkg::filt_res_t  res
);

  localparam int SUM_W = 2 * gspt_pkg::SMOOTH_W - 1;
  localparam logic signed [SUM_W-1:0] W_NEW = SUM_W'(gspt_pkg::SMOOTH_Q8);
  localparam logic signed [SUM_W-1:0] W_OLD = SUM_W'(256 - gspt_pkg::SMOOTH_Q8);

  logic signed [gspt_pkg::SMOOTH_W-1:0] sx_r, sy_r;
  logic [gspt_pkg::CNT_W-1:0]           cnt_r;
  logic                                 acc_r;

  logic signed [gspt_pkg::ERR_W-1:0]    dx, dy;
  logic [gspt_pkg::ERR_W-1:0]           adx, ady;
  logic [gspt_pkg::THR_W-1:0]           thr;
  logic                                 empty, outlier;
  logic signed [SUM_W-1:0]              sum_x, sum_y, tx, ty;

  always_comb begin
    empty = (sx_r == '0) && (sy_r == '0);
    dx  = gspt_pkg::ERR_W'(req.raw_x) - gspt_pkg::ERR_W'(sx_r);
    dy  = gspt_pkg::ERR_W'(req.raw_y) - gspt_pkg::ERR_W'(sy_r);
    adx = (dx < 0) ? gspt_pkg::ERR_W'(-dx) : gspt_pkg::ERR_W'(dx);
    ady = (dy < 0) ? gspt_pkg::ERR_W'(-dy) : gspt_pkg::ERR_W'(dy);
    thr = gspt_pkg::THR_W'(gspt_pkg::GATE_BASE)
        + gspt_pkg::THR_W'(cnt_r) * gspt_pkg::THR_W'(gspt_pkg::GATE_STEP);
    outlier = (gspt_pkg::THR_W'(adx) > thr) || (gspt_pkg::THR_W'(ady) > thr)
           || (adx > gspt_pkg::ERR_W'(thr)) || (ady > gspt_pkg::ERR_W'(thr));
    sum_x = W_NEW * SUM_W'(req.raw_x) + W_OLD * SUM_W'(sx_r);
    sum_y = W_NEW * SUM_W'(req.raw_y) + W_OLD * SUM_W'(sy_r);
    // truncate toward zero
    tx = sum_x + ((sum_x < 0) ? SUM_W'(255) : SUM_W'(0));
    ty = sum_y + ((sum_y < 0) ? SUM_W'(255) : SUM_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r  <= '0;
      sy_r  <= '0;
      cnt_r <= '0;
      acc_r <= 1'b1;
    end else if (req.go) begin
      if (empty) begin
        // empty filter: restart from the raw point
        sx_r  <= req.raw_x;
        sy_r  <= req.raw_y;
        acc_r <= 1'b1;
      end else if (outlier) begin
        acc_r <= 1'b0;
        if (cnt_r != gspt_pkg::CNT_W'(gspt_pkg::CNT_MAX)) cnt_r <= cnt_r + 1'b1;
      end else begin
        sx_r  <= gspt_pkg::SMOOTH_W'(tx >>> 8);
        sy_r  <= gspt_pkg::SMOOTH_W'(ty >>> 8);
        acc_r <= 1'b1;
        if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign res.accepted = acc_r;
  assign res.smooth_x = sx_r;
  assign res.smooth_y = sy_r;

endmodule

// File: rtl/core/gspt_axis.sv
module gspt_axis (
  input  logic                clk,
  input  logic                rst_n,
  input  gspt_pkg::lane_req_t req,
  input  gspt_pkg::gains_t    gains,
  output gspt_pkg::lane_res_t res
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL_P,
    L_MUL_I,
    L_MUL_D,
    L_SUM
  } lane_state_t;

  localparam logic signed [gspt_pkg::ERR_W-1:0] DB = gspt_pkg::ERR_W'(gspt_pkg::DEAD_BAND);

  lane_state_t                           state_r;
  logic signed [gspt_pkg::ERR_W-1:0]     err_r, prev_err_r;
  logic signed [gspt_pkg::INTEG_W-1:0]   integ_r;
  logic signed [gspt_pkg::PROD_W-1:0]    prod_r;
  logic signed [gspt_pkg::Q_W-1:0]       p_r;
  logic signed [gspt_pkg::STEP_W-1:0]    step_r;
  logic                                  done_r;

  logic                                  dead;
  logic signed [gspt_pkg::DIFF_W-1:0]    mul_a;
  logic [gspt_pkg::GAIN_W-1:0]           mul_b;
  logic signed [gspt_pkg::PROD_W-1:0]    prod_nxt;
  logic signed [gspt_pkg::Q_W-1:0]       q;
  logic signed [gspt_pkg::IACC_W-1:0]    integ_sum;
  logic signed [gspt_pkg::SSUM_W-1:0]    step_sum;

  always_comb begin
    dead = (req.err >= -DB) && (req.err <= DB);
    unique case (state_r)
      L_MUL_I: begin
        mul_a = gspt_pkg::DIFF_W'(err_r);
        mul_b = gains.ki;
      end
      L_MUL_D: begin
        mul_a = gspt_pkg::DIFF_W'(err_r) - gspt_pkg::DIFF_W'(prev_err_r);
        mul_b = gains.kd;
      end
      default: begin
        mul_a = gspt_pkg::DIFF_W'(err_r);
        mul_b = gains.kp;
      end
    endcase
    // one shared multiplier, gain is unsigned
    prod_nxt  = gspt_pkg::PROD_W'(mul_a) * $signed({{(gspt_pkg::PROD_W-gspt_pkg::GAIN_W){1'b0}},
                                                    mul_b});
    q         = gspt_pkg::qdiv(prod_r);
    integ_sum = gspt_pkg::IACC_W'(integ_r) + gspt_pkg::IACC_W'(q);
    step_sum  = gspt_pkg::SSUM_W'(p_r) + gspt_pkg::SSUM_W'(integ_r) + gspt_pkg::SSUM_W'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= L_IDLE;
      done_r     <= 1'b0;
      prev_err_r <= '0;
      integ_r    <= '0;
    end else begin
      unique case (state_r)
        L_IDLE: begin
          if (req.start) begin
            err_r  <= req.err;
            done_r <= dead;
            if (dead) begin
              integ_r <= '0;
              step_r  <= '0;
            end else begin
              state_r <= L_MUL_P;
            end
          end
        end
        L_MUL_P: begin
          prod_r  <= prod_nxt;
          state_r <= L_MUL_I;
        end
        L_MUL_I: begin
          p_r     <= q;
          prod_r  <= prod_nxt;
          state_r <= L_MUL_D;
        end
        L_MUL_D: begin
          integ_r    <= gspt_pkg::sat_integ(integ_sum);
          prod_r     <= prod_nxt;
          prev_err_r <= err_r;
          state_r    <= L_SUM;
        end
        L_SUM: begin
          step_r  <= gspt_pkg::sat_step(step_sum);
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.step = step_r;

endmodule

// File: rtl/core/gated_smoothing_pid_tracker_top.sv
// Path: an input item runs through the filter and both PID lanes, then merges into
//   the output register once that is free; a lane in the dead band skips its products.
// Items: one at a time; the next item is taken once the previous result is in the
//   output register (the PID lanes share one multiplier each over three products).
// Reset: rst_n synchronous, active low; filter, PID and position state clear,
//   configuration registers return to their defaults.
module gated_smoothing_pid_tracker_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [gspt_pkg::COORD_W-1:0]            in_point_x,
  input  logic [gspt_pkg::COORD_W-1:0]            in_point_y,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_accepted,
  output logic signed [gspt_pkg::SMOOTH_W-1:0]    out_smooth_x,
  output logic signed [gspt_pkg::SMOOTH_W-1:0]    out_smooth_y,
  output logic signed [gspt_pkg::STEP_OUT_W-1:0]  out_step_x,
  output logic signed [gspt_pkg::STEP_OUT_W-1:0]  out_step_y,
  output logic signed [gspt_pkg::POS_W-1:0]       out_motor_pos_x,
  output logic signed [gspt_pkg::POS_W-1:0]       out_motor_pos_y,
  // configuration
  input  logic                                    cfg_we,
  input  logic [gspt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gspt_pkg::CFG_DATA_W-1:0]         cfg_data
);

  // Sequencer: take item, run gate/smoothing, fire both PID lanes,
  // then merge the two steps into the position accumulators.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_LANE,
    S_WAIT,
    S_MERGE
  } top_state_t;

  top_state_t state_r;

  // Configuration registers
  logic [gspt_pkg::COORD_W-1:0] aim_x_r, aim_y_r;
  gspt_pkg::gains_t             gx_r, gy_r;

  // Captured item (y already flipped)
  logic signed [gspt_pkg::SMOOTH_W-1:0] raw_x_r, raw_y_r;

  // Position accumulators
  logic signed [gspt_pkg::POS_W-1:0] pos_x_r, pos_y_r;

  // Output register
  logic                                   out_valid_r;
  logic                                   acc_o_r;
  logic signed [gspt_pkg::SMOOTH_W-1:0]   sx_o_r, sy_o_r;
  logic signed [gspt_pkg::STEP_OUT_W-1:0] stx_o_r, sty_o_r;

  gspt_pkg::filt_req_t filt_req;
  gspt_pkg::filt_res_t filt_res;
  gspt_pkg::lane_req_t req_x, req_y;
  gspt_pkg::lane_res_t res_x, res_y;

  logic signed [gspt_pkg::POS_W-1:0] pos_x_nxt, pos_y_nxt;
  logic                              load_out;

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_MERGE) && (!out_valid_r || out_ready);

  // Configuration writes, taken at any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aim_x_r <= gspt_pkg::AIM_X_RST;
      aim_y_r <= gspt_pkg::AIM_Y_RST;
      gx_r    <= '{kp: gspt_pkg::KP_X_RST, ki: '0, kd: '0};
      gy_r    <= '{kp: gspt_pkg::KP_Y_RST, ki: '0, kd: '0};
    end else if (cfg_we) begin
      unique case (gspt_pkg::reg_idx_t'(cfg_index))
        gspt_pkg::REG_AIM_X: aim_x_r <= cfg_data[gspt_pkg::COORD_W-1:0];
        gspt_pkg::REG_AIM_Y: aim_y_r <= cfg_data[gspt_pkg::COORD_W-1:0];
        gspt_pkg::REG_KP_X:  gx_r.kp <= cfg_data;
        gspt_pkg::REG_KI_X:  gx_r.ki <= cfg_data;
        gspt_pkg::REG_KD_X:  gx_r.kd <= cfg_data;
        gspt_pkg::REG_KP_Y:  gy_r.kp <= cfg_data;
        gspt_pkg::REG_KI_Y:  gy_r.ki <= cfg_data;
        gspt_pkg::REG_KD_Y:  gy_r.kd <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gate and smoothing stage
  always_comb begin
    filt_req.go    = (state_r == S_FILT);
    filt_req.raw_x = raw_x_r;
    filt_req.raw_y = raw_y_r;
  end

  gspt_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (filt_req),
    .res   (filt_res)
  );

  // Lane requests: error against the aim point
  always_comb begin
    req_x.start = (state_r == S_LANE);
    req_x.err   = $signed({2'b00, aim_x_r}) - gspt_pkg::ERR_W'(filt_res.smooth_x);
    req_y.start = (state_r == S_LANE);
    req_y.err   = $signed({2'b00, aim_y_r}) - gspt_pkg::ERR_W'(filt_res.smooth_y);
  end

  gspt_axis u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_x),
    .gains (gx_r),
    .res   (res_x)
  );

  gspt_axis u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_y),
    .gains (gy_r),
    .res   (res_y)
  );

  // Merge: x moves against its step, y with it; both wrap
  always_comb begin
    pos_x_nxt = pos_x_r - gspt_pkg::POS_W'(res_x.step);
    pos_y_nxt = pos_y_r + gspt_pkg::POS_W'(res_y.step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            raw_x_r <= $signed({1'b0, in_point_x});
            raw_y_r <= gspt_pkg::SMOOTH_W'(gspt_pkg::FRAME_HEIGHT)
                     - $signed({1'b0, in_point_y});
            state_r <= S_FILT;
          end
        end
        S_FILT:  state_r <= S_LANE;
        S_LANE:  state_r <= S_WAIT;
        S_WAIT: begin
          if (res_x.done && res_y.done) state_r <= S_MERGE;
        end
        S_MERGE: begin
          if (load_out) begin
            pos_x_r <= pos_x_nxt;
            pos_y_r <= pos_y_nxt;
            acc_o_r <= filt_res.accepted;
            sx_o_r  <= filt_res.smooth_x;
            sy_o_r  <= filt_res.smooth_y;
            stx_o_r <= res_x.step[gspt_pkg::STEP_OUT_W-1:0];
            sty_o_r <= res_y.step[gspt_pkg::STEP_OUT_W-1:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = acc_o_r;
  assign out_smooth_x    = sx_o_r;
  assign out_smooth_y    = sy_o_r;
  assign out_step_x      = stx_o_r;
  assign out_step_y      = sty_o_r;
  assign out_motor_pos_x = pos_x_r;
  assign out_motor_pos_y = pos_y_r;

endmodule
